[design/mfrx_pkg.sv]
// Package for the frame receiver with XOR check.
// Holds item kind codes, frame status codes, layout constants and the queued
// item type. No dependencies.
package mfrx_pkg;

  // Item kinds, decoded from tuser
  typedef enum logic [1:0] {
    OP_LINE    = 2'd0,
    OP_READ    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  // Frame status codes reported with each result
  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_ACCEPT   = 2'd1,
    ST_MISMATCH = 2'd2,
    ST_NOT_ADDR = 2'd3
  } status_e;

  // Frame layout
  localparam logic [7:0] MinPayload    = 8'd16;
  localparam logic [8:0] FrameOverhead = 9'd4;
  localparam logic [7:0] BroadcastAddr = 8'hFF;
  localparam logic [8:0] HeaderBytes   = 9'd3;

  // Configuration register map
  localparam logic [2:0] RegStationAddr = 3'd0;

  // One classified input item
  typedef struct packed {
    op_e        kind;
    logic [7:0] line_byte;
    logic       gap_timeout;
    logic [7:0] read_index;
  } op_t;

  // One result item
  typedef struct packed {
    logic [7:0] delivered_length;
    logic [7:0] delivered_source;
    logic [7:0] read_data;
    logic       frame_available;
    status_e    frame_status;
  } result_t;

endpackage

[design/mfrx_front.sv]
// Front stage: registers an accepted input transfer and classifies it.
// Depends on mfrx_pkg.
module mfrx_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    in_func_i,
  input  logic [7:0]    in_line_byte_i,
  input  logic          in_gap_timeout_i,
  input  logic [7:0]    in_read_index_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mfrx_pkg::op_t out_op_o
);
  import mfrx_pkg::*;

  logic valid_q, valid_d;
  op_t  op_q, op_d;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_op_o    = op_q;

  // Decode the kind and capture the payload
  always_comb begin
    op_d = op_q;
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      op_d.kind        = op_e'(in_func_i);
      op_d.line_byte   = in_line_byte_i;
      op_d.gap_timeout = (op_e'(in_func_i) == OP_LINE) ? in_gap_timeout_i : 1'b0;
      op_d.read_index  = in_read_index_i;
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
  end

endmodule

[design/mfrx_queue.sv]
// Two-entry queue of classified items between front and back.
// Depends on mfrx_pkg.
module mfrx_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mfrx_pkg::op_t in_op_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mfrx_pkg::op_t out_op_o
);
  import mfrx_pkg::*;

  op_t        ent_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign in_ready_o  = (count_q != 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign out_op_o    = ent_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= in_op_i;
    end
  end

endmodule

[design/mfrx_back.sv]
// Back stage: frame tracking, XOR check, address filter, ping-pong payload
// memory and the result register. Depends on mfrx_pkg.
module mfrx_back #(
  parameter int PAYLOAD_DEPTH = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        station_addr_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mfrx_pkg::op_t     in_op_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mfrx_pkg::result_t out_res_o
);
  import mfrx_pkg::*;

  localparam int IdxW  = $clog2(PAYLOAD_DEPTH);
  localparam int AddrW = IdxW + 1;
  localparam int MemDepth = 2 ** AddrW;
  localparam logic [8:0] DepthLim = 9'(PAYLOAD_DEPTH);

  // Frame tracking state
  logic [8:0] pos_q, pos_d;
  logic [7:0] dest_q, dest_d;
  logic [7:0] src_q, src_d;
  logic [7:0] len_q, len_d;
  logic [8:0] total_q, total_d;
  logic [7:0] chk_q, chk_d;
  logic       bank_q, bank_d;
  logic [7:0] held_src_q, held_src_d;
  logic [7:0] held_len_q, held_len_d;
  logic       held_valid_q, held_valid_d;

  // Result register
  logic       ovalid_q, ovalid_d;
  status_e    status_q, status_d;
  logic       avail_q;
  logic [7:0] dsrc_q, dlen_q;
  logic       rd_en_q, rd_en_d;
  logic [7:0] rd_q;

  // Payload memory
  logic [7:0]       mem_q [MemDepth];
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [AddrW-1:0] rd_addr;

  logic       exec;
  logic [8:0] pos_eff;
  logic [7:0] chk_eff;
  logic [8:0] pay_idx;
  logic [7:0] lb;

  assign in_ready_o  = !ovalid_q || out_ready_i;
  assign exec        = in_valid_i && in_ready_o;
  assign out_valid_o = ovalid_q;

  assign out_res_o.frame_status     = status_q;
  assign out_res_o.frame_available  = avail_q;
  assign out_res_o.read_data        = rd_en_q ? rd_q : 8'd0;
  assign out_res_o.delivered_source = dsrc_q;
  assign out_res_o.delivered_length = dlen_q;

  assign lb      = in_op_i.line_byte;
  assign pos_eff = in_op_i.gap_timeout ? 9'd0 : pos_q;
  assign chk_eff = in_op_i.gap_timeout ? 8'd0 : chk_q;
  assign pay_idx = pos_eff - HeaderBytes;
  assign rd_addr = {!bank_q, in_op_i.read_index[IdxW-1:0]};

  // Execute one item
  always_comb begin
    pos_d        = pos_q;
    dest_d       = dest_q;
    src_d        = src_q;
    len_d        = len_q;
    total_d      = total_q;
    chk_d        = chk_q;
    bank_d       = bank_q;
    held_src_d   = held_src_q;
    held_len_d   = held_len_q;
    held_valid_d = held_valid_q;
    status_d     = ST_NONE;
    rd_en_d      = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = {bank_q, pay_idx[IdxW-1:0]};
    case (in_op_i.kind)
      OP_LINE: begin
        pos_d = pos_eff + 9'd1;
        chk_d = chk_eff;
        if (pos_eff == 9'd0) begin
          dest_d = lb;
          chk_d  = chk_eff ^ lb;
        end else if (pos_eff == 9'd1) begin
          src_d = lb;
          chk_d = chk_eff ^ lb;
        end else if (pos_eff == 9'd2) begin
          len_d   = lb;
          chk_d   = chk_eff ^ lb;
          total_d = {1'b0, (lb < MinPayload) ? MinPayload : lb} + FrameOverhead;
        end else if (pos_eff == total_q - 9'd1) begin
          // Frame end: check, then address filter
          if (lb != chk_eff) begin
            status_d = ST_MISMATCH;
          end else if (dest_q != station_addr_i && dest_q != BroadcastAddr) begin
            status_d = ST_NOT_ADDR;
          end else begin
            status_d     = ST_ACCEPT;
            held_src_d   = src_q;
            held_len_d   = len_q;
            held_valid_d = 1'b1;
            bank_d       = !bank_q;
          end
          pos_d = 9'd0;
          chk_d = 8'd0;
        end else begin
          // Payload or padding byte
          wr_en = (pay_idx < DepthLim);
          if (pay_idx < {1'b0, len_q}) begin
            chk_d = chk_eff ^ lb;
          end
        end
      end
      OP_READ: begin
        rd_en_d = held_valid_q && (in_op_i.read_index < held_len_q) &&
                  ({1'b0, in_op_i.read_index} < DepthLim);
      end
      OP_RELEASE: begin
        held_valid_d = 1'b0;
        held_src_d   = 8'd0;
        held_len_d   = 8'd0;
      end
      default: begin
      end
    endcase
    if (!exec) begin
      wr_en = 1'b0;
    end
  end

  always_comb begin
    if (exec) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end else begin
      ovalid_d = ovalid_q;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= 9'd0;
      dest_q       <= 8'd0;
      src_q        <= 8'd0;
      len_q        <= 8'd0;
      total_q      <= 9'd0;
      chk_q        <= 8'd0;
      bank_q       <= 1'b0;
      held_src_q   <= 8'd0;
      held_len_q   <= 8'd0;
      held_valid_q <= 1'b0;
      ovalid_q     <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
      if (exec) begin
        pos_q        <= pos_d;
        dest_q       <= dest_d;
        src_q        <= src_d;
        len_q        <= len_d;
        total_q      <= total_d;
        chk_q        <= chk_d;
        bank_q       <= bank_d;
        held_src_q   <= held_src_d;
        held_len_q   <= held_len_d;
        held_valid_q <= held_valid_d;
      end
    end
  end

  // Result payload, held while the output stalls
  always_ff @(posedge clk_i) begin
    if (exec) begin
      status_q <= status_d;
      avail_q  <= held_valid_d;
      dsrc_q   <= held_valid_d ? held_src_d : 8'd0;
      dlen_q   <= held_valid_d ? held_len_d : 8'd0;
      rd_en_q  <= rd_en_d;
    end
  end

  // Payload memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= lb;
    end
    if (exec) begin
      rd_q <= mem_q[rd_addr];
    end
  end

endmodule

[design/mac_frame_receiver_xor_check.sv]
// Frame receiver with XOR check, address filter and ping-pong delivery bank.
// An item passes the front register, the queue and the result register in
// that order, and is held longer while the output stalls. Throughput: one
// item per cycle unless the output stalls; per item, the back stage does
// one registered memory read and at most one write. Reset is asynchronous,
// active low; it clears all control state. The payload memory is not cleared.
module mac_frame_receiver_xor_check #(
  parameter int PAYLOAD_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] line_byte, [8] gap_timeout, [16:9] read_index, [23:17] zero
  input  logic [23:0] s_axis_tdata,
  // [1:0] func
  input  logic [1:0]  s_axis_tuser,
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] frame_status, [2] frame_available, [10:3] read_data,
  // [18:11] delivered_source, [26:19] delivered_length, [31:27] zero
  output logic [31:0] m_axis_tdata,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mfrx_pkg::*;

  logic       station_wr;
  logic [7:0] station_addr_q;
  logic       fr_valid, fr_ready;
  op_t        fr_op;
  logic       qu_valid, qu_ready;
  op_t        qu_op;
  result_t    res;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == RegStationAddr) ? {24'd0, station_addr_q} : 32'd0;
  assign station_wr = psel && penable && pwrite && (paddr == RegStationAddr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_addr_q <= 8'd0;
    end else if (station_wr) begin
      station_addr_q <= pwdata[7:0];
    end
  end

  mfrx_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .in_func_i        (s_axis_tuser),
    .in_line_byte_i   (s_axis_tdata[7:0]),
    .in_gap_timeout_i (s_axis_tdata[8]),
    .in_read_index_i  (s_axis_tdata[16:9]),
    .out_valid_o      (fr_valid),
    .out_ready_i      (fr_ready),
    .out_op_o         (fr_op)
  );

  mfrx_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_op_i     (fr_op),
    .out_valid_o (qu_valid),
    .out_ready_i (qu_ready),
    .out_op_o    (qu_op)
  );

  mfrx_back #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .station_addr_i (station_addr_q),
    .in_valid_i     (qu_valid),
    .in_ready_o     (qu_ready),
    .in_op_i        (qu_op),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_res_o      (res)
  );

  // Result packing, first field in the lowest bits
  assign m_axis_tdata = {5'd0, res.delivered_length, res.delivered_source,
                         res.read_data, res.frame_available, res.frame_status};

endmodule
